### sv/dual_wheel_pid_speed_control_macros.svh
// assertion macros for the dual wheel pid speed controller checker
`ifndef DUAL_WHEEL_PID_SPEED_CONTROL_MACROS_SVH
`define DUAL_WHEEL_PID_SPEED_CONTROL_MACROS_SVH

// same-cycle implication, disabled in reset
`define DWPC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dwpc check failed");

// next-cycle implication, disabled in reset
`define DWPC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dwpc check failed");

`endif

### sv/dwpc_pkg.sv
// shared types, widths and constants of the dual wheel pid speed controller
package dwpc_pkg;

   localparam int WINDOW_DEPTH = 32;
   localparam int POS_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

   localparam int DES_W = 20;
   localparam int MEAS_W = 24;
   localparam int ERR_W = 25;
   localparam int SUM_W = ERR_W + POS_W + 1;
   localparam int GAIN_W = 16;
   localparam int ILIM_W = 20;
   localparam int OLIM_W = 15;
   localparam int THR_W = 15;
   localparam int WGT_W = 9;
   localparam int CMD_W = 16;

   localparam int MUL_A_W = 18;
   localparam int MUL_B_W = 26;
   localparam int PROD_W = MUL_A_W + MUL_B_W;
   localparam int ACC_W = PROD_W + 2;
   localparam int CMD_FRAC = 12;
   localparam int QUOT_W = ACC_W - CMD_FRAC;
   localparam int DIFF_W = CMD_W + 1;
   localparam int BLEND_FRAC = 8;
   localparam int BLEND_W = 28;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 20;

   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_I = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_D = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_INT_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_LIMIT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SLEW_THR = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_BLEND_WGT = 3'd6;

   localparam logic [GAIN_W-1:0] RST_GAIN_P = 16'd1229;
   localparam logic [GAIN_W-1:0] RST_GAIN_I = 16'd128;
   localparam logic [GAIN_W-1:0] RST_GAIN_D = 16'd77;
   localparam logic [ILIM_W-1:0] RST_INT_LIMIT = 20'd18000;
   localparam logic [OLIM_W-1:0] RST_OUT_LIMIT = 15'd28000;
   localparam logic [THR_W-1:0] RST_SLEW_THR = 15'd400;
   localparam logic [WGT_W-1:0] RST_BLEND_WGT = 9'd26;
   localparam logic [WGT_W-1:0] WGT_FULL = 9'd256;

   typedef struct packed {
      logic [GAIN_W-1:0] gain_p;
      logic [GAIN_W-1:0] gain_i;
      logic [GAIN_W-1:0] gain_d;
      logic [ILIM_W-1:0] int_limit;
      logic [OLIM_W-1:0] out_limit;
      logic [THR_W-1:0] slew_thr;
      logic [WGT_W-1:0] blend_wgt;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_P,
      ST_CLAMP,
      ST_MUL_I,
      ST_MUL_D,
      ST_ACC,
      ST_CMD,
      ST_BLEND,
      ST_FINAL
   } seq_state_type;

   typedef struct packed {
      logic load;
      logic mul_p;
      logic clamp;
      logic mul_i;
      logic mul_d;
      logic acc;
      logic cmd;
      logic blend;
      logic commit;
      logic full;
      logic [POS_W-1:0] addr;
   } step_type;

endpackage

### sv/dwpc_ram.sv
// generic single write port ram with registered read
module dwpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/dwpc_seq.sv
// step sequencer, ring position and fill flag shared by both lanes
module dwpc_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              out_free,
   output logic              busy,
   output dwpc_pkg::step_type step
);

   localparam logic [dwpc_pkg::POS_W-1:0] LAST_POS =
      dwpc_pkg::POS_W'(dwpc_pkg::WINDOW_DEPTH - 1);

   dwpc_pkg::seq_state_type state_ff, state_in;
   logic [dwpc_pkg::POS_W-1:0] pos_ff, pos_in;
   logic full_ff, full_in;
   logic commit;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dwpc_pkg::ST_IDLE:  if (req_valid) state_in = dwpc_pkg::ST_MUL_P;
         dwpc_pkg::ST_MUL_P: state_in = dwpc_pkg::ST_CLAMP;
         dwpc_pkg::ST_CLAMP: state_in = dwpc_pkg::ST_MUL_I;
         dwpc_pkg::ST_MUL_I: state_in = dwpc_pkg::ST_MUL_D;
         dwpc_pkg::ST_MUL_D: state_in = dwpc_pkg::ST_ACC;
         dwpc_pkg::ST_ACC:   state_in = dwpc_pkg::ST_CMD;
         dwpc_pkg::ST_CMD:   state_in = dwpc_pkg::ST_BLEND;
         dwpc_pkg::ST_BLEND: state_in = dwpc_pkg::ST_FINAL;
         dwpc_pkg::ST_FINAL: if (out_free) state_in = dwpc_pkg::ST_IDLE;
         default:            state_in = dwpc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      step = '0;
      step.addr = pos_ff;
      step.full = full_ff;
      busy = 1'b1;
      unique case (state_ff)
         dwpc_pkg::ST_IDLE: begin
            busy = 1'b0;
            step.load = req_valid;
         end
         dwpc_pkg::ST_MUL_P: step.mul_p = 1'b1;
         dwpc_pkg::ST_CLAMP: step.clamp = 1'b1;
         dwpc_pkg::ST_MUL_I: step.mul_i = 1'b1;
         dwpc_pkg::ST_MUL_D: step.mul_d = 1'b1;
         dwpc_pkg::ST_ACC:   step.acc = 1'b1;
         dwpc_pkg::ST_CMD:   step.cmd = 1'b1;
         dwpc_pkg::ST_BLEND: step.blend = 1'b1;
         dwpc_pkg::ST_FINAL: step.commit = out_free;
         default:            busy = 1'b1;
      endcase
   end

   assign commit = step.commit;

   always_comb begin
      pos_in = pos_ff;
      full_in = full_ff;
      if (commit) begin
         if (pos_ff == LAST_POS) begin
            pos_in = '0;
            full_in = 1'b1;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dwpc_pkg::ST_IDLE;
         pos_ff <= '0;
         full_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff <= pos_in;
         full_ff <= full_in;
      end
   end

endmodule

### sv/dwpc_lane.sv
// one wheel's pid core: error ring, shared multiplier, clamps and slew blend
module dwpc_lane (
   input  logic                                clock,
   input  logic                                reset,
   input  dwpc_pkg::step_type                  step,
   input  dwpc_pkg::cfg_type                   cfg,
   input  logic signed [dwpc_pkg::DES_W-1:0]   desired,
   input  logic signed [dwpc_pkg::MEAS_W-1:0]  measured,
   output logic signed [dwpc_pkg::CMD_W-1:0]   final_cmd
);

   localparam int ERR_W = dwpc_pkg::ERR_W;
   localparam int SUM_W = dwpc_pkg::SUM_W;
   localparam int PAD_A = dwpc_pkg::MUL_A_W - dwpc_pkg::GAIN_W;
   localparam int PAD_W = dwpc_pkg::MUL_A_W - dwpc_pkg::WGT_W;

   logic signed [ERR_W-1:0] err_ff, err_in;
   logic signed [ERR_W-1:0] prev_err_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic signed [ERR_W-1:0] isum_ff;
   logic signed [dwpc_pkg::PROD_W-1:0] prod_ff;
   logic signed [dwpc_pkg::ACC_W-1:0] acc_ff;
   logic signed [dwpc_pkg::CMD_W-1:0] cmd_ff, cmd_in;
   logic signed [dwpc_pkg::CMD_W-1:0] prev_cmd_ff;
   logic over_ff;

   logic [ERR_W-1:0] ring_rd;
   logic signed [ERR_W-1:0] old_err;
   logic signed [SUM_W-1:0] sum_lim;
   logic signed [ERR_W-1:0] isum_in;
   logic signed [dwpc_pkg::MUL_A_W-1:0] mul_a;
   logic signed [dwpc_pkg::MUL_B_W-1:0] mul_b;
   logic signed [dwpc_pkg::PROD_W-1:0] mul_out;
   logic signed [dwpc_pkg::MUL_B_W-1:0] derr;
   logic [dwpc_pkg::WGT_W-1:0] wgt;
   logic signed [dwpc_pkg::ACC_W-1:0] acc_bias;
   logic signed [dwpc_pkg::QUOT_W-1:0] quot, olim;
   logic signed [dwpc_pkg::DIFF_W-1:0] cdiff;
   logic [dwpc_pkg::DIFF_W-1:0] cdiff_abs;
   logic signed [dwpc_pkg::BLEND_W-1:0] blend_sum, blend_bias;
   logic signed [dwpc_pkg::CMD_W-1:0] blended;

   dwpc_ram #(
      .WIDTH (ERR_W),
      .DEPTH (dwpc_pkg::WINDOW_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (step.mul_p),
      .wr_addr (step.addr),
      .wr_data (err_ff),
      .rd_en   (step.load),
      .rd_addr (step.addr),
      .rd_data (ring_rd)
   );

   // error in 1/16 tick/s
   assign err_in = (ERR_W'(desired) <<< 4) - ERR_W'(measured);

   // entries not yet written since reset read as zero
   assign old_err = step.full ? $signed(ring_rd) : '0;

   // windowed sum clamp
   assign sum_lim = SUM_W'({cfg.int_limit, 4'b0000});
   always_comb begin
      if (sum_ff > sum_lim) begin
         isum_in = ERR_W'(sum_lim);
      end else if (sum_ff < -sum_lim) begin
         isum_in = ERR_W'(-sum_lim);
      end else begin
         isum_in = ERR_W'(sum_ff);
      end
   end

   assign derr = dwpc_pkg::MUL_B_W'(prev_err_ff) - dwpc_pkg::MUL_B_W'(err_ff);
   assign wgt = (cfg.blend_wgt > dwpc_pkg::WGT_FULL) ? dwpc_pkg::WGT_FULL : cfg.blend_wgt;
   assign cdiff = dwpc_pkg::DIFF_W'(cmd_ff) - dwpc_pkg::DIFF_W'(prev_cmd_ff);
   assign cdiff_abs = cdiff[dwpc_pkg::DIFF_W-1] ? $unsigned(-cdiff) : $unsigned(cdiff);

   // operand select for the shared multiplier
   always_comb begin
      priority if (step.mul_i) begin
         mul_a = $signed({{PAD_A{1'b0}}, cfg.gain_i});
         mul_b = dwpc_pkg::MUL_B_W'(isum_ff);
      end else if (step.mul_d) begin
         mul_a = $signed({{PAD_A{1'b0}}, cfg.gain_d});
         mul_b = derr;
      end else if (step.blend) begin
         mul_a = $signed({{PAD_W{1'b0}}, wgt});
         mul_b = dwpc_pkg::MUL_B_W'(cdiff);
      end else begin
         mul_a = $signed({{PAD_A{1'b0}}, cfg.gain_p});
         mul_b = dwpc_pkg::MUL_B_W'(err_ff);
      end
   end

   assign mul_out = mul_a * mul_b;

   // divide by 4096 toward zero, then clamp to the output limit
   assign acc_bias = acc_ff + (acc_ff[dwpc_pkg::ACC_W-1] ?
                     dwpc_pkg::ACC_W'(4095) : dwpc_pkg::ACC_W'(0));
   assign quot = $signed(acc_bias[dwpc_pkg::ACC_W-1:dwpc_pkg::CMD_FRAC]);
   assign olim = dwpc_pkg::QUOT_W'(cfg.out_limit);
   always_comb begin
      if (quot > olim) begin
         cmd_in = dwpc_pkg::CMD_W'(olim);
      end else if (quot < -olim) begin
         cmd_in = dwpc_pkg::CMD_W'(-olim);
      end else begin
         cmd_in = dwpc_pkg::CMD_W'(quot);
      end
   end

   // blend: w*(new-old) + 256*old, divided by 256 toward zero
   assign blend_sum = dwpc_pkg::BLEND_W'(prod_ff) +
                      (dwpc_pkg::BLEND_W'(prev_cmd_ff) <<< dwpc_pkg::BLEND_FRAC);
   assign blend_bias = blend_sum + (blend_sum[dwpc_pkg::BLEND_W-1] ?
                       dwpc_pkg::BLEND_W'(255) : dwpc_pkg::BLEND_W'(0));
   assign blended = dwpc_pkg::CMD_W'(blend_bias >>> dwpc_pkg::BLEND_FRAC);
   assign final_cmd = over_ff ? blended : cmd_ff;

   // datapath
   always_ff @(posedge clock) begin
      if (step.load) begin
         err_ff <= err_in;
      end
      if (step.clamp) begin
         isum_ff <= isum_in;
         acc_ff <= dwpc_pkg::ACC_W'(prod_ff);
      end else if (step.mul_d || step.acc) begin
         acc_ff <= acc_ff + dwpc_pkg::ACC_W'(prod_ff);
      end
      if (step.mul_p || step.mul_i || step.mul_d || step.blend) begin
         prod_ff <= mul_out;
      end
      if (step.cmd) begin
         cmd_ff <= cmd_in;
      end
      if (step.blend) begin
         over_ff <= cdiff_abs > dwpc_pkg::DIFF_W'(cfg.slew_thr);
      end
   end

   // wheel state
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         prev_err_ff <= '0;
         prev_cmd_ff <= '0;
      end else begin
         if (step.mul_p) begin
            sum_ff <= sum_ff + SUM_W'(err_ff) - SUM_W'(old_err);
         end
         if (step.cmd) begin
            prev_err_ff <= err_ff;
         end
         if (step.commit) begin
            prev_cmd_ff <= final_cmd;
         end
      end
   end

endmodule

### sv/dual_wheel_pid_speed_control.sv
// top level of the dual wheel pid speed controller
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  desired_left/right, measured_left/right
//  rsp      out        rsp_valid/rsp_stall  drive_left, drive_right
//  csr      in         csr_wr_en            csr_index, csr_wdata
//
// the result of an item is registered at the final step, and the next item is
// taken only once the sequencer is back in idle, so items do not overlap: both lanes
// share a step sequencer and each lane runs p, i, d and blend through one multiplier
// reset clears the error rings logically (fill flag), sums, previous errors
// and commands, and loads the register defaults; no clearing pass
// a waiting result does not stop acceptance of the next item; only the
// final step holds while the output register is still full and stalled
module dual_wheel_pid_speed_control (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic signed [dwpc_pkg::DES_W-1:0]          req_desired_left,
   input  logic signed [dwpc_pkg::DES_W-1:0]          req_desired_right,
   input  logic signed [dwpc_pkg::MEAS_W-1:0]         req_measured_left,
   input  logic signed [dwpc_pkg::MEAS_W-1:0]         req_measured_right,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic signed [dwpc_pkg::CMD_W-1:0]          rsp_drive_left,
   output logic signed [dwpc_pkg::CMD_W-1:0]          rsp_drive_right,
   input  logic                                       csr_wr_en,
   input  logic [dwpc_pkg::CSR_IDX_W-1:0]             csr_index,
   input  logic [dwpc_pkg::CSR_DATA_W-1:0]            csr_wdata
);

   dwpc_pkg::cfg_type cfg_ff, cfg_in;
   dwpc_pkg::step_type step;
   logic busy;
   logic out_free;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [dwpc_pkg::CMD_W-1:0] cmd_left, cmd_right;
   logic signed [dwpc_pkg::CMD_W-1:0] drive_left_ff, drive_right_ff;

   // configuration registers, unknown indexes ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            dwpc_pkg::REG_GAIN_P:    cfg_in.gain_p = csr_wdata[dwpc_pkg::GAIN_W-1:0];
            dwpc_pkg::REG_GAIN_I:    cfg_in.gain_i = csr_wdata[dwpc_pkg::GAIN_W-1:0];
            dwpc_pkg::REG_GAIN_D:    cfg_in.gain_d = csr_wdata[dwpc_pkg::GAIN_W-1:0];
            dwpc_pkg::REG_INT_LIMIT: cfg_in.int_limit = csr_wdata[dwpc_pkg::ILIM_W-1:0];
            dwpc_pkg::REG_OUT_LIMIT: cfg_in.out_limit = csr_wdata[dwpc_pkg::OLIM_W-1:0];
            dwpc_pkg::REG_SLEW_THR:  cfg_in.slew_thr = csr_wdata[dwpc_pkg::THR_W-1:0];
            dwpc_pkg::REG_BLEND_WGT: cfg_in.blend_wgt = csr_wdata[dwpc_pkg::WGT_W-1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p <= dwpc_pkg::RST_GAIN_P;
         cfg_ff.gain_i <= dwpc_pkg::RST_GAIN_I;
         cfg_ff.gain_d <= dwpc_pkg::RST_GAIN_D;
         cfg_ff.int_limit <= dwpc_pkg::RST_INT_LIMIT;
         cfg_ff.out_limit <= dwpc_pkg::RST_OUT_LIMIT;
         cfg_ff.slew_thr <= dwpc_pkg::RST_SLEW_THR;
         cfg_ff.blend_wgt <= dwpc_pkg::RST_BLEND_WGT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // output register can take a result when empty or being drained
   assign out_free = !rsp_valid_ff || !rsp_stall;

   dwpc_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .busy      (busy),
      .step      (step)
   );

   assign req_stall = busy;

   // left and right lanes run in lockstep on the same steps
   dwpc_lane u_lane_left (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .cfg       (cfg_ff),
      .desired   (req_desired_left),
      .measured  (req_measured_left),
      .final_cmd (cmd_left)
   );

   dwpc_lane u_lane_right (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .cfg       (cfg_ff),
      .desired   (req_desired_right),
      .measured  (req_measured_right),
      .final_cmd (cmd_right)
   );

   // merge: both lane commands negated into one result item
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step.commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step.commit) begin
         drive_left_ff <= -cmd_left;
         drive_right_ff <= -cmd_right;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive_left = drive_left_ff;
   assign rsp_drive_right = drive_right_ff;

endmodule

### sv/dwpc_checker.sv
// port level checks for the dual wheel pid speed controller, with bind
`include "dual_wheel_pid_speed_control_macros.svh"

module dwpc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic signed [dwpc_pkg::CMD_W-1:0] rsp_drive_left,
   input logic signed [dwpc_pkg::CMD_W-1:0] rsp_drive_right
);

   // a stalled result holds
   `DWPC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_drive_left) && $stable(rsp_drive_right))

   // the block is busy right after taking an item
   `DWPC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // a new result only leaves a busy block
   `DWPC_ASSERT_NOW(a_rsp_from_busy, clock, reset, $rose(rsp_valid), $past(req_stall))

   // commands stay inside the symmetric 16 bit range
   `DWPC_ASSERT_NOW(a_drive_range, clock, reset, rsp_valid, rsp_drive_left != 16'sh8000 && rsp_drive_right != 16'sh8000)

endmodule

bind dual_wheel_pid_speed_control dwpc_checker u_dwpc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_drive_left  (rsp_drive_left),
   .rsp_drive_right (rsp_drive_right)
);
